// File: hw/rtl/tbpf_pkg.sv
// shared types and constants of the tile background pixel fetch unit
package tbpf_pkg;

  localparam int VMEM_DEPTH       = 8192;
  localparam int VMEM_AW          = $clog2(VMEM_DEPTH);
  localparam int VMEM_WORDS       = VMEM_DEPTH / 2;
  localparam int VMEM_WAW         = $clog2(VMEM_WORDS);
  localparam int SCREEN_WIDTH_DEF = 160;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] PALETTE_RST      = 8'hFC;
  localparam logic [1:0] MAP_BASE_HI      = 2'b11;
  localparam logic [8:0] SIGNED_TILE_BASE = 9'h080;
  localparam logic [7:0] TILE_SIGN_FLIP   = 8'h80;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_RENDER = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BG_ENABLE   = 3'd0,
    CFG_MAP_SELECT  = 3'd1,
    CFG_DATA_SELECT = 3'd2,
    CFG_SCROLL_Y    = 3'd3,
    CFG_SCROLL_X    = 3'd4,
    CFG_PALETTE     = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic               en;
    logic [VMEM_AW-1:0] addr;
    logic [7:0]         data;
  } vram_wr_t;

endpackage

// File: hw/rtl/tbpf_if.sv
// input and result channel interfaces of the tile background pixel fetch unit
interface tbpf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [tbpf_pkg::VMEM_AW-1:0]  mem_addr;
  logic [7:0]                    mem_data;
  logic [7:0]                    pixel_x;
  logic [7:0]                    pixel_line;

  modport source (output valid, func, mem_addr, mem_data, pixel_x, pixel_line,
                  input ready);
  modport sink (input valid, func, mem_addr, mem_data, pixel_x, pixel_line,
                output ready);
endinterface

interface tbpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_x;
  logic [7:0] out_line;
  logic [1:0] shade;

  modport source (output valid, out_x, out_line, shade, input ready);
  modport sink (input valid, out_x, out_line, shade, output ready);
endinterface

// File: hw/rtl/tbpf_vram.sv
// video memory: 16-bit words, byte write, two registered read ports
module tbpf_vram (
  input  logic                          clk,
  input  tbpf_pkg::vram_wr_t            wr,
  input  logic                          rd0_en,
  input  logic [tbpf_pkg::VMEM_WAW-1:0] rd0_addr,
  output logic [15:0]                   rd0_data,
  input  logic                          rd1_en,
  input  logic [tbpf_pkg::VMEM_WAW-1:0] rd1_addr,
  output logic [15:0]                   rd1_data
);

  logic [15:0] mem [tbpf_pkg::VMEM_WORDS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.addr[0]) begin
        mem[wr.addr[tbpf_pkg::VMEM_AW-1:1]][15:8] <= wr.data;
      end else begin
        mem[wr.addr[tbpf_pkg::VMEM_AW-1:1]][7:0] <= wr.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd0_en) begin
      rd0_data <= mem[rd0_addr];
    end
    if (rd1_en) begin
      rd1_data <= mem[rd1_addr];
    end
  end

endmodule

// File: hw/rtl/tile_background_pixel_fetch_unit.sv
// top level of the tile background pixel fetch unit
// Takes one beat per cycle, write or render, unless stalled, and returns one pixel per cycle
// while the receiver is ready. A write beat stores its byte in video memory at the accepting
// edge and returns nothing. A render beat reads its tile map entry at the accepting edge and its
// tile row word as stage 1 advances; stage 2 forms its shade. A column at or beyond SCREEN_WIDTH
// returns nothing. The pipeline moves as one and stops only when the two-entry result buffer
// is full and its last stage holds a pixel; the buffer lets new beats in while a result waits.
// Memory contents are undefined until written; there is no clearing pass.
module tile_background_pixel_fetch_unit #(
  parameter int SCREEN_WIDTH = tbpf_pkg::SCREEN_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  tbpf_in_if.sink                           in_bus,
  tbpf_out_if.source                        out_bus,
  input  logic                              cfg_we,
  input  logic [tbpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tbpf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic       bg_enable_r;
  logic       map_select_r;
  logic       data_select_r;
  logic [7:0] scroll_y_r;
  logic [7:0] scroll_x_r;
  logic [7:0] palette_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_enable_r   <= 1'b0;
      map_select_r  <= 1'b0;
      data_select_r <= 1'b0;
      scroll_y_r    <= 8'd0;
      scroll_x_r    <= 8'd0;
      palette_r     <= tbpf_pkg::PALETTE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tbpf_pkg::CFG_BG_ENABLE:   bg_enable_r   <= cfg_wdata[0];
        tbpf_pkg::CFG_MAP_SELECT:  map_select_r  <= cfg_wdata[0];
        tbpf_pkg::CFG_DATA_SELECT: data_select_r <= cfg_wdata[0];
        tbpf_pkg::CFG_SCROLL_Y:    scroll_y_r    <= cfg_wdata;
        tbpf_pkg::CFG_SCROLL_X:    scroll_x_r    <= cfg_wdata;
        tbpf_pkg::CFG_PALETTE:     palette_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic       s1_valid_r, s2_valid_r;
  logic [1:0] cnt_r;
  logic       adv, accept, render, push, pop;

  assign adv    = (cnt_r != 2'd2) || !s2_valid_r;
  assign accept = in_bus.valid && adv;
  assign render = accept && (in_bus.func == tbpf_pkg::FUNC_RENDER)
                  && ({1'b0, in_bus.pixel_x} < 9'(SCREEN_WIDTH));
  assign push   = adv && s2_valid_r;
  assign pop    = out_bus.valid && out_bus.ready;

  assign in_bus.ready = adv;

  // stage 0: map address
  logic [7:0]                   bx, by;
  logic [tbpf_pkg::VMEM_AW-1:0] map_addr;
  tbpf_pkg::vram_wr_t           vwr;

  assign bx       = in_bus.pixel_x + scroll_x_r;
  assign by       = in_bus.pixel_line + scroll_y_r;
  assign map_addr = {tbpf_pkg::MAP_BASE_HI, map_select_r, by[7:3], bx[7:3]};

  always_comb begin
    vwr.en   = accept && (in_bus.func == tbpf_pkg::FUNC_WRITE);
    vwr.addr = in_bus.mem_addr;
    vwr.data = in_bus.mem_data;
  end

  // stage 1: tile number arrives, tile row address
  logic [7:0] s1_x_r, s1_line_r;
  logic [2:0] s1_fx_r, s1_fy_r;
  logic       s1_odd_r;
  logic [15:0] map_word, row_word;
  logic [7:0]  tile;
  logic [8:0]  tile_base;
  logic [tbpf_pkg::VMEM_WAW-1:0] row_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= render;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x_r    <= in_bus.pixel_x;
      s1_line_r <= in_bus.pixel_line;
      s1_fx_r   <= bx[2:0];
      s1_fy_r   <= by[2:0];
      s1_odd_r  <= map_addr[0];
    end
  end

  assign tile      = s1_odd_r ? map_word[15:8] : map_word[7:0];
  assign tile_base = data_select_r ? {1'b0, tile}
                     : tbpf_pkg::SIGNED_TILE_BASE + {1'b0, tile ^ tbpf_pkg::TILE_SIGN_FLIP};
  assign row_addr  = {tile_base, s1_fy_r};

  tbpf_vram u_vram (
    .clk      (clk),
    .wr       (vwr),
    .rd0_en   (adv),
    .rd0_addr (map_addr[tbpf_pkg::VMEM_AW-1:1]),
    .rd0_data (map_word),
    .rd1_en   (adv),
    .rd1_addr (row_addr),
    .rd1_data (row_word)
  );

  // stage 2: bitplanes arrive, shade
  logic [7:0] s2_x_r, s2_line_r;
  logic [2:0] s2_fx_r;
  logic [2:0] bit_sel;
  logic [1:0] colour, shade;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_x_r    <= s1_x_r;
      s2_line_r <= s1_line_r;
      s2_fx_r   <= s1_fx_r;
    end
  end

  assign bit_sel = 3'd7 - s2_fx_r;
  assign colour  = {row_word[{1'b1, bit_sel}], row_word[{1'b0, bit_sel}]};
  assign shade   = bg_enable_r ? palette_r[{colour, 1'b0} +: 2] : 2'd0;

  // result buffer
  logic [7:0] buf_x_r    [2];
  logic [7:0] buf_line_r [2];
  logic [1:0] buf_shade_r[2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_x_r[wr_ptr_r]     <= s2_x_r;
      buf_line_r[wr_ptr_r]  <= s2_line_r;
      buf_shade_r[wr_ptr_r] <= shade;
    end
  end

  assign out_bus.valid    = (cnt_r != 2'd0);
  assign out_bus.out_x    = buf_x_r[rd_ptr_r];
  assign out_bus.out_line = buf_line_r[rd_ptr_r];
  assign out_bus.shade    = buf_shade_r[rd_ptr_r];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && cnt_r == 2'd2))
    else $error("result buffer overflow");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s1_valid_r) && $stable(s2_valid_r))
    else $error("pipeline moved while stalled");

  a_bg_off_shade: assert property (@(posedge clk) disable iff (!rst_n)
    push && !bg_enable_r |=> buf_shade_r[$past(wr_ptr_r)] == 2'd0)
    else $error("nonzero shade with background disabled");

endmodule

// File: test/testbench.sv
// self-checking testbench of the tile background pixel fetch unit with its own shade predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [tbpf_pkg::VMEM_AW-1:0] vaddr_t;

  typedef struct packed {
    logic       func;
    vaddr_t     addr;
    logic [7:0] data;
    logic [7:0] px;
    logic [7:0] line;
  } vram_beat_t;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] line;
    logic [1:0] shade;
  } pixel_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [tbpf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tbpf_pkg::CFG_DATA_W-1:0] cfg_wdata;

  tbpf_in_if  in_bus ();
  tbpf_out_if out_bus ();

  tile_background_pixel_fetch_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // register copies
  bit         bg_on          = 1'b0;
  bit         map_hi         = 1'b0;
  bit         unsigned_tiles = 1'b0;
  logic [7:0] scy            = 8'd0;
  logic [7:0] scx            = 8'd0;
  logic [7:0] pal            = tbpf_pkg::PALETTE_RST;

  logic [7:0] vram_model   [tbpf_pkg::VMEM_DEPTH];
  logic [7:0] plan_mem     [tbpf_pkg::VMEM_DEPTH];
  bit         plan_written [tbpf_pkg::VMEM_DEPTH];

  vram_beat_t beats_to_send [$];
  pixel_t     pixels_due [$];
  vram_beat_t next_beat;
  pixel_t     due_pixel;

  int bad_fields     = 0;
  int ready_hold     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit beat_taken     = 1'b0;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic vaddr_t map_entry(logic [7:0] x, logic [7:0] line);
    logic [7:0] bx;
    logic [7:0] by;
    bx = x + scx;
    by = line + scy;
    return {tbpf_pkg::MAP_BASE_HI, map_hi, by[7:3], bx[7:3]};
  endfunction

  function automatic vaddr_t tile_row(logic [7:0] tile, logic [7:0] line);
    logic [7:0] by;
    logic [8:0] slot;
    by   = line + scy;
    slot = unsigned_tiles ? {1'b0, tile}
           : tbpf_pkg::SIGNED_TILE_BASE + {1'b0, tile ^ tbpf_pkg::TILE_SIGN_FLIP};
    return {slot, by[2:0], 1'b0};
  endfunction

  function automatic logic [1:0] shade_at(logic [7:0] x, logic [7:0] line);
    vaddr_t     row;
    logic [7:0] bx;
    logic [2:0] bit_pos;
    logic [1:0] colour;
    if (!bg_on) return 2'd0;
    row     = tile_row(vram_model[map_entry(x, line)], line);
    bx      = x + scx;
    bit_pos = 3'd7 - bx[2:0];
    colour  = {vram_model[row | 13'd1][bit_pos], vram_model[row][bit_pos]};
    return pal[{colour, 1'b0} +: 2];
  endfunction

  task automatic note_bad(string what, int got, int want);
    bad_fields++;
    $display("%0t ns: %s got %0d want %0d", $time, what, got, want);
  endtask

  function automatic void push_write(vaddr_t addr, logic [7:0] data);
    vram_beat_t b;
    b.func = tbpf_pkg::FUNC_WRITE;
    b.addr = addr;
    b.data = data;
    b.px   = 8'($urandom);
    b.line = 8'($urandom);
    plan_mem[addr]     = data;
    plan_written[addr] = 1'b1;
    beats_to_send.push_back(b);
  endfunction

  // writes whatever the pixel reads that is unwritten, or all of it on rewrite
  function automatic void plan_pixel(logic [7:0] x, logic [7:0] line, bit rewrite,
                                     logic [7:0] tile, logic [7:0] lo, logic [7:0] hi);
    vaddr_t     entry;
    vaddr_t     row;
    vram_beat_t b;
    entry = map_entry(x, line);
    if (rewrite || !plan_written[entry]) push_write(entry, rewrite ? tile : 8'($urandom));
    row = tile_row(plan_mem[entry], line);
    if (rewrite || !plan_written[row]) push_write(row, rewrite ? lo : 8'($urandom));
    if (rewrite || !plan_written[row | 13'd1])
      push_write(row | 13'd1, rewrite ? hi : 8'($urandom));
    b.func = tbpf_pkg::FUNC_RENDER;
    b.addr = vaddr_t'($urandom);
    b.data = 8'($urandom);
    b.px   = x;
    b.line = line;
    beats_to_send.push_back(b);
  endfunction

  function automatic void plan_random(int count);
    int         goal;
    int         run;
    logic [7:0] x;
    logic [7:0] line;
    goal = beats_to_send.size() + count;
    while (beats_to_send.size() < goal) begin
      if ($urandom_range(4) == 0) begin
        push_write(vaddr_t'($urandom), 8'($urandom));
      end else begin
        x    = ($urandom_range(7) == 0) ? 8'($urandom_range(255, 160)) : 8'($urandom_range(159));
        line = 8'($urandom_range(255));
        run  = ($urandom_range(3) == 0) ? $urandom_range(8, 2) : 1;
        for (int i = 0; i < run; i++)
          plan_pixel(x + 8'(i), line, $urandom_range(3) == 0,
                     8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endfunction

  task automatic write_reg(tbpf_pkg::cfg_idx_t idx, logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tbpf_pkg::CFG_BG_ENABLE:   bg_on = value[0];
      tbpf_pkg::CFG_MAP_SELECT:  map_hi = value[0];
      tbpf_pkg::CFG_DATA_SELECT: unsigned_tiles = value[0];
      tbpf_pkg::CFG_SCROLL_Y:    scy = value;
      tbpf_pkg::CFG_SCROLL_X:    scx = value;
      tbpf_pkg::CFG_PALETTE:     pal = value;
      default: ;
    endcase
  endtask

  task automatic set_regs(bit en, bit map_sel, bit data_sel, logic [7:0] sy, logic [7:0] sx,
                          logic [7:0] p);
    write_reg(tbpf_pkg::CFG_BG_ENABLE, {7'd0, en});
    write_reg(tbpf_pkg::CFG_MAP_SELECT, {7'd0, map_sel});
    write_reg(tbpf_pkg::CFG_DATA_SELECT, {7'd0, data_sel});
    write_reg(tbpf_pkg::CFG_SCROLL_Y, sy);
    write_reg(tbpf_pkg::CFG_SCROLL_X, sx);
    write_reg(tbpf_pkg::CFG_PALETTE, p);
  endtask

  task automatic set_idling(idling_t mode);
    @(posedge clk);
    case (mode)
      IDLE_SENDER:   begin send_idle_pct = 57; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 57; end
      IDLE_BOTH:     begin send_idle_pct = 30; recv_stall_pct = 30; end
      default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  task automatic wait_idle();
    while (beats_to_send.size() != 0 || in_bus.valid === 1'b1 || pixels_due.size() != 0)
      @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || beat_taken) begin
      if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_beat = beats_to_send.pop_front();
        in_bus.valid      <= 1'b1;
        in_bus.func       <= next_beat.func;
        in_bus.mem_addr   <= next_beat.addr;
        in_bus.mem_data   <= next_beat.data;
        in_bus.pixel_x    <= next_beat.px;
        in_bus.pixel_line <= next_beat.line;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
    beat_taken = 1'b0;
  end

  // result ready, with long hold-off when asked
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (ready_hold > 0) begin
      out_bus.ready <= 1'b0;
      ready_hold = ready_hold - 1;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result check, then prediction for the accepted beat
  always @(posedge clk) begin
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready) begin
      if (pixels_due.size() == 0) begin
        note_bad("pixel with none due, out_x", out_bus.out_x, 0);
      end else begin
        due_pixel = pixels_due.pop_front();
        if (out_bus.out_x !== due_pixel.x) note_bad("out_x", out_bus.out_x, due_pixel.x);
        if (out_bus.out_line !== due_pixel.line)
          note_bad("out_line", out_bus.out_line, due_pixel.line);
        if (out_bus.shade !== due_pixel.shade)
          note_bad("shade", out_bus.shade, due_pixel.shade);
      end
    end
    if (rst_n && in_bus.valid && in_bus.ready === 1'b1) begin
      beat_taken = 1'b1;
      if (in_bus.func == tbpf_pkg::FUNC_WRITE) begin
        vram_model[in_bus.mem_addr] = in_bus.mem_data;
      end else if (in_bus.pixel_x < tbpf_pkg::SCREEN_WIDTH_DEF) begin
        pixels_due.push_back('{in_bus.pixel_x, in_bus.pixel_line,
                               shade_at(in_bus.pixel_x, in_bus.pixel_line)});
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_bus.valid      = 1'b0;
    in_bus.func       = tbpf_pkg::FUNC_WRITE;
    in_bus.mem_addr   = '0;
    in_bus.mem_data   = '0;
    in_bus.pixel_x    = '0;
    in_bus.pixel_line = '0;
    out_bus.ready     = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: background off, signed tiles, map 0
    set_idling(IDLE_NONE);
    plan_pixel(8'd0, 8'd0, 1'b1, 8'h80, 8'hFF, 8'h00);
    plan_pixel(8'd159, 8'd255, 1'b1, 8'h7F, 8'h00, 8'hFF);
    plan_pixel(8'd160, 8'd0, 1'b0, 8'h00, 8'h00, 8'h00);
    plan_random(60);
    wait_idle();

    set_regs(1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'hE4);
    set_idling(IDLE_NONE);
    plan_pixel(8'd0, 8'd0, 1'b0, 8'h00, 8'h00, 8'h00);
    plan_pixel(8'd159, 8'd143, 1'b1, 8'h7F, 8'h55, 8'hAA);
    plan_pixel(8'd255, 8'd144, 1'b0, 8'h00, 8'h00, 8'h00);
    plan_random(150);
    wait_idle();

    set_regs(1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'h1B);
    set_idling(IDLE_SENDER);
    plan_pixel(8'd0, 8'd0, 1'b1, 8'hFF, 8'hF0, 8'h0F);
    plan_pixel(8'd1, 8'd1, 1'b1, 8'h00, 8'hFF, 8'hFF);
    plan_random(150);
    wait_idle();

    set_regs(1'b1, 1'b0, 1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
             8'($urandom_range(255)));
    set_idling(IDLE_RECEIVER);
    plan_random(150);
    wait_idle();

    set_regs(1'b1, 1'b1, 1'b0, 8'h80, 8'h7F, 8'hFF);
    set_idling(IDLE_BOTH);
    plan_random(150);
    wait_idle();

    set_regs(1'b0, 1'($urandom), 1'($urandom), 8'($urandom_range(255)),
             8'($urandom_range(255)), 8'($urandom_range(255)));
    set_idling(IDLE_BOTH);
    plan_random(100);
    wait_idle();

    // receiver held off while beats keep coming, then sender waits for the drain
    set_regs(1'b1, 1'($urandom), 1'($urandom), 8'($urandom_range(255)),
             8'($urandom_range(255)), 8'($urandom_range(255)));
    set_idling(IDLE_NONE);
    ready_hold = 300;
    plan_random(120);
    wait_idle();
    plan_random(120);
    wait_idle();

    set_regs(1'b1, 1'b1, 1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)), 8'h00);
    set_idling(IDLE_RECEIVER);
    plan_random(230);
    wait_idle();

    if (bad_fields == 0) begin
      $display("tile_background_pixel_fetch_unit: match");
    end else begin
      $display("tile_background_pixel_fetch_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tile_background_pixel_fetch_unit: mismatch");
    $finish;
  end

endmodule
